// ===== design/cttr_pkg.sv =====
// Package for the codon translator: the queue entry type, error and register codes,
// and the standard genetic code tables. Used by every module of the block.
// No dependencies.
package cttr_pkg;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
    localparam logic [1:0] ERR_SHORT    = 2'd2;

    localparam logic CFG_THREE_LETTER = 1'b0;
    localparam logic CFG_TEMPLATE     = 1'b1;

    localparam logic [1:0] BASE_U = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_A = 2'd2;
    localparam logic [1:0] BASE_G = 2'd3;

    localparam logic [7:0] CHAR_STOP  = "!";
    localparam logic [7:0] CHAR_SPACE = " ";

    localparam logic [1:0] LAST_BEAT = 2'd3;

    typedef struct packed {
        logic [1:0] error_code;
        logic [5:0] codon_index;
        logic       three_letter;
        logic       done;
    } t_job;

    localparam logic [7:0] ONE_LETTER [64] = '{
        "F","S","Y","C","F","S","Y","C","L","S","!","!","L","S","!","W",
        "L","P","H","R","L","P","H","R","L","P","Q","R","L","P","Q","R",
        "I","T","N","S","I","T","N","S","I","T","K","R","M","T","K","R",
        "V","A","D","G","V","A","D","G","V","A","E","G","V","A","E","G"
    };

    localparam logic [23:0] THREE_LETTER [64] = '{
        "Phe","Ser","Tyr","Cys","Phe","Ser","Tyr","Cys",
        "Leu","Ser","STP","STP","Leu","Ser","STP","Trp",
        "Leu","Pro","His","Arg","Leu","Pro","His","Arg",
        "Leu","Pro","Gln","Arg","Leu","Pro","Gln","Arg",
        "Ile","Thr","Asn","Ser","Ile","Thr","Asn","Ser",
        "Ile","Thr","Lys","Arg","Met","Thr","Lys","Arg",
        "Val","Ala","Asp","Gly","Val","Ala","Asp","Gly",
        "Val","Ala","Glu","Gly","Val","Ala","Glu","Gly"
    };

endpackage

// ===== design/cttr_in_if.sv =====
// Input channel of the codon translator: one ASCII nucleotide per transaction.
// No dependencies.
interface cttr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] nucleotide;
    logic       end_of_sequence;

    modport source (output valid, output nucleotide, output end_of_sequence, input ready);
    modport sink (input valid, input nucleotide, input end_of_sequence, output ready);
endinterface

// ===== design/cttr_out_if.sv =====
// Output channel of the codon translator: one output character per transaction.
// No dependencies.
interface cttr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic [5:0] codon_index;
    logic       is_stop;
    logic [1:0] error_code;
    logic       last_of_run;
    logic       sequence_done;

    modport source (
        output valid, output symbol, output codon_index, output is_stop,
        output error_code, output last_of_run, output sequence_done, input ready
    );
    modport sink (
        input valid, input symbol, input codon_index, input is_stop,
        input error_code, input last_of_run, input sequence_done, output ready
    );
endinterface

// ===== design/cttr_front.sv =====
// Front end of the codon translator: maps characters to bases, assembles codons
// and pushes codon and error jobs into the queue. Depends on cttr_pkg and cttr_in_if.
module cttr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_three_letter,
    input  logic            i_template,
    cttr_in_if.sink         i_in,
    output logic            o_push_valid,
    output cttr_pkg::t_job  o_push_job,
    input  logic            i_push_ready
);

    logic [3:0] r_pending;
    logic [1:0] r_position;
    logic       r_discard;
    logic [3:0] n_pending;
    logic [1:0] n_position;
    logic       n_discard;

    logic [7:0] upper;
    logic [1:0] base;
    logic       base_ok;
    logic       accept;
    logic       eos;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid && i_push_ready;
    assign eos        = i_in.end_of_sequence;

    always_comb begin
        upper = i_in.nucleotide;
        if (i_in.nucleotide >= "a" && i_in.nucleotide <= "z") begin
            upper = i_in.nucleotide - 8'd32;
        end
        base    = cttr_pkg::BASE_U;
        base_ok = 1'b1;
        if (i_template) begin
            case (upper)
                "A":     base = cttr_pkg::BASE_U;
                "T":     base = cttr_pkg::BASE_A;
                "G":     base = cttr_pkg::BASE_C;
                "C":     base = cttr_pkg::BASE_G;
                default: base_ok = 1'b0;
            endcase
        end else begin
            case (upper)
                "U":     base = cttr_pkg::BASE_U;
                "T":     base = cttr_pkg::BASE_U;
                "C":     base = cttr_pkg::BASE_C;
                "A":     base = cttr_pkg::BASE_A;
                "G":     base = cttr_pkg::BASE_G;
                default: base_ok = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_pending    = r_pending;
        n_position   = r_position;
        n_discard    = r_discard;
        o_push_valid = 1'b0;
        o_push_job   = '{
            error_code:   cttr_pkg::ERR_NONE,
            codon_index:  6'd0,
            three_letter: 1'b0,
            done:         1'b1
        };
        if (r_discard) begin
            if (eos) begin
                n_discard  = 1'b0;
                n_position = 2'd0;
                n_pending  = 4'd0;
            end
        end else if (!base_ok) begin
            o_push_valid          = i_in.valid;
            o_push_job.error_code = cttr_pkg::ERR_BAD_CHAR;
            n_position            = 2'd0;
            n_pending             = 4'd0;
            n_discard             = !eos;
        end else if (r_position < 2'd2) begin
            n_pending  = {r_pending[1:0], base};
            n_position = r_position + 2'd1;
            if (eos) begin
                o_push_valid          = i_in.valid;
                o_push_job.error_code = cttr_pkg::ERR_SHORT;
                n_position            = 2'd0;
                n_pending             = 4'd0;
            end
        end else begin
            o_push_valid            = i_in.valid;
            o_push_job.codon_index  = {r_pending[3:2], base, r_pending[1:0]};
            o_push_job.three_letter = i_three_letter;
            o_push_job.done         = eos;
            n_position              = 2'd0;
            n_pending               = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 4'd0;
            r_position <= 2'd0;
            r_discard  <= 1'b0;
        end else if (accept) begin
            r_pending  <= n_pending;
            r_position <= n_position;
            r_discard  <= n_discard;
        end
    end

endmodule

// ===== design/cttr_queue.sv =====
// Small job queue between the front end and the output sequencer of the codon
// translator. Depends on cttr_pkg.
module cttr_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  cttr_pkg::t_job  i_push_job,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output cttr_pkg::t_job  o_pop_job,
    input  logic            i_pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cttr_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_head];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_tail] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_tail <= (r_tail == LAST_PTR) ? '0 : r_tail + PTR_W'(1);
            end
            if (pop) begin
                r_head <= (r_head == LAST_PTR) ? '0 : r_head + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== design/cttr_back.sv =====
// Output sequencer of the codon translator: expands each job into one or four
// characters and holds them in an output register. Depends on cttr_pkg and cttr_out_if.
module cttr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  cttr_pkg::t_job  i_job,
    output logic            o_job_pop,
    cttr_out_if.source      o_out
);

    logic [1:0]  r_beat;
    logic        r_valid;
    logic [7:0]  r_symbol;
    logic [5:0]  r_codon_index;
    logic        r_is_stop;
    logic [1:0]  r_error_code;
    logic        r_last;
    logic        r_done;

    logic [7:0]  n_symbol;
    logic        n_last;
    logic        is_error;
    logic        load;
    logic [23:0] name;

    assign is_error  = (i_job.error_code != cttr_pkg::ERR_NONE);
    assign name      = cttr_pkg::THREE_LETTER[i_job.codon_index];
    assign load      = !r_valid || o_out.ready;
    assign n_last    = !i_job.three_letter || (r_beat == cttr_pkg::LAST_BEAT);
    assign o_job_pop = load && i_job_valid && n_last;

    always_comb begin
        if (is_error) begin
            n_symbol = 8'd0;
        end else if (!i_job.three_letter) begin
            n_symbol = cttr_pkg::ONE_LETTER[i_job.codon_index];
        end else begin
            case (r_beat)
                2'd0:    n_symbol = name[23:16];
                2'd1:    n_symbol = name[15:8];
                2'd2:    n_symbol = name[7:0];
                default: n_symbol = cttr_pkg::CHAR_SPACE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else if (load) begin
            r_valid <= i_job_valid;
            if (i_job_valid) begin
                r_beat        <= n_last ? 2'd0 : r_beat + 2'd1;
                r_symbol      <= n_symbol;
                r_codon_index <= is_error ? 6'd0 : i_job.codon_index;
                r_is_stop     <= !is_error &&
                    (cttr_pkg::ONE_LETTER[i_job.codon_index] == cttr_pkg::CHAR_STOP);
                r_error_code  <= i_job.error_code;
                r_last        <= n_last;
                r_done        <= n_last && i_job.done;
            end
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.symbol        = r_symbol;
    assign o_out.codon_index   = r_codon_index;
    assign o_out.is_stop       = r_is_stop;
    assign o_out.error_code    = r_error_code;
    assign o_out.last_of_run   = r_last;
    assign o_out.sequence_done = r_done;

endmodule

// ===== design/codon_to_amino_acid_translator_top.sv =====
// Top level of the codon translator: configuration registers, front end, job queue
// and output sequencer. Depends on cttr_pkg, cttr_in_if, cttr_out_if and the submodules.
//
//   Channel   Direction  Contents
//   i_nuc     in         nucleotide (8), end_of_sequence (1)
//   o_res     out        symbol, codon_index, is_stop, error_code, last_of_run, sequence_done
//   i_cfg_*   in         write enable, register index, write data
//
// A nucleotide is accepted whenever the job queue has room.
// A codon in one-letter mode or an error yields one output character; a codon in
// three-letter mode yields four, the three-letter name and a space, and the
// output register holds a single character at a time.
// Synchronous reset clears the control state and template flag; three-letter mode is set.
// The queue lets the input keep flowing while the output is stalled, until it fills.
module codon_to_amino_acid_translator_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    cttr_in_if.sink     i_nuc,
    cttr_out_if.source  o_res
);

    logic           r_three_letter;
    logic           r_template;
    logic           push_valid;
    logic           push_ready;
    cttr_pkg::t_job push_job;
    logic           pop_valid;
    logic           pop_ready;
    cttr_pkg::t_job pop_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_letter <= 1'b1;
            r_template     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cttr_pkg::CFG_THREE_LETTER: r_three_letter <= i_cfg_data;
                cttr_pkg::CFG_TEMPLATE:     r_template     <= i_cfg_data;
                default:                    r_template     <= r_template;
            endcase
        end
    end

    cttr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_three_letter (r_three_letter),
        .i_template     (r_template),
        .i_in           (i_nuc),
        .o_push_valid   (push_valid),
        .o_push_job     (push_job),
        .i_push_ready   (push_ready)
    );

    cttr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_job   (push_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_job    (pop_job),
        .i_pop_ready  (pop_ready)
    );

    cttr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .i_job       (pop_job),
        .o_job_pop   (pop_ready),
        .o_out       (o_res)
    );

endmodule
